// ===== rtl/vctf_pkg.sv =====
// ----------------------------------------------------------------------------
// vctf_pkg
// Shared types, format codes and helpers for the vertex component converter.
// ----------------------------------------------------------------------------
package vctf_pkg;

	localparam logic [3:0] FMT_S8     = 4'd0;
	localparam logic [3:0] FMT_U8     = 4'd1;
	localparam logic [3:0] FMT_S16    = 4'd2;
	localparam logic [3:0] FMT_U16    = 4'd3;
	localparam logic [3:0] FMT_S32    = 4'd4;
	localparam logic [3:0] FMT_U32    = 4'd5;
	localparam logic [3:0] FMT_FLOAT  = 4'd6;
	localparam logic [3:0] FMT_DOUBLE = 4'd7;

	localparam logic [3:0] REG_FORMAT = 4'd0;
	localparam logic [3:0] REG_NORM   = 4'd1;

	localparam logic [31:0] F32_ONE   = 32'h3f80_0000;
	localparam logic [31:0] F32_INF   = 32'h7f80_0000;
	localparam logic [31:0] F32_QNAN  = 32'h7fc0_0000;

	// decoded request, ready for the alignment shift
	typedef struct packed {
		logic        special;   // spec_val is the final result
		logic [31:0] spec_val;
		logic        sign;
		logic [63:0] wpre;      // significand window, aligned by the lsh then rsh shift
		logic [4:0]  lsh;
		logic [4:0]  rsh;
		logic [7:0]  eadj;      // biased exponent minus one
		logic        force_st;  // value has an endless binary expansion
	} dec_t;

	function automatic logic [4:0] lzc32(input logic [31:0] x);
		logic [4:0] n;
		n = 5'd0;
		for (int i = 0; i < 32; i++) begin
			if (x[i]) n = 5'(31 - i);
		end
		return n;
	endfunction

endpackage

// ===== rtl/vctf_decode.sv =====
// ----------------------------------------------------------------------------
// vctf_decode
// Splits a raw component into sign, significand window, shifts and exponent.
// ----------------------------------------------------------------------------
module vctf_decode (
	input  logic [3:0]    fmt,
	input  logic          norm,
	input  logic [63:0]   raw,
	output vctf_pkg::dec_t dec
);

	logic        sgn;
	logic [31:0] mag;
	logic [15:0] nmag;
	logic [15:0] unity;
	logic        use_norm;
	logic        is_int;
	logic [63:0] rep;
	logic [4:0]  lz;
	logic [10:0] de;
	logic [10:0] dsh;

	always_comb begin
		sgn      = 1'b0;
		mag      = 32'd0;
		unity    = 16'd0;
		rep      = 64'd0;
		is_int   = 1'b0;
		use_norm = 1'b0;
		nmag     = 16'd0;
		case (fmt)
			vctf_pkg::FMT_S8: begin
				sgn  = raw[7];
				nmag = {8'd0, sgn ? 8'(-raw[7:0]) : raw[7:0]};
				unity = 16'd127;
				rep = 64'({10{nmag[6:0]}} >> 6);
				is_int = 1'b1; use_norm = norm;
			end
			vctf_pkg::FMT_U8: begin
				nmag = {8'd0, raw[7:0]};
				unity = 16'd255;
				rep = {8{nmag[7:0]}};
				is_int = 1'b1; use_norm = norm;
			end
			vctf_pkg::FMT_S16: begin
				sgn  = raw[15];
				nmag = sgn ? 16'(-raw[15:0]) : raw[15:0];
				unity = 16'd32767;
				rep = 64'({5{nmag[14:0]}} >> 11);
				is_int = 1'b1; use_norm = norm;
			end
			vctf_pkg::FMT_U16: begin
				nmag = raw[15:0];
				unity = 16'd65535;
				rep = {4{nmag}};
				is_int = 1'b1; use_norm = norm;
			end
			vctf_pkg::FMT_S32: begin
				sgn = raw[31];
				is_int = 1'b1;
			end
			vctf_pkg::FMT_U32: begin
				is_int = 1'b1;
			end
			default: begin
			end
		endcase
		if (fmt == vctf_pkg::FMT_S32) mag = sgn ? 32'(-raw[31:0]) : raw[31:0];
		else if (fmt == vctf_pkg::FMT_U32) mag = raw[31:0];
		else mag = {16'd0, nmag};
	end

	assign lz  = vctf_pkg::lzc32(use_norm ? rep[63:32] : mag);
	assign de  = raw[62:52];
	assign dsh = 11'd897 - de;

	always_comb begin
		dec          = '0;
		dec.sign     = sgn;
		if (is_int && use_norm) begin
			if (nmag == 16'd0) begin
				dec.special = 1'b1;
			end else if (nmag == unity) begin
				dec.special  = 1'b1;
				dec.spec_val = {sgn, 31'd0} | vctf_pkg::F32_ONE;
			end else if (nmag > unity) begin
				dec.special  = 1'b1;
				dec.spec_val = {1'b1, 31'd0} | vctf_pkg::F32_ONE;
			end else begin
				dec.wpre     = rep;
				dec.lsh      = lz;
				dec.eadj     = 8'd125 - {3'd0, lz};
				dec.force_st = 1'b1;
			end
		end else if (is_int) begin
			if (mag == 32'd0) begin
				dec.special = 1'b1;
			end else begin
				dec.wpre = {mag, 32'd0};
				dec.lsh  = lz;
				dec.eadj = 8'd157 - {3'd0, lz};
			end
		end else if (fmt == vctf_pkg::FMT_FLOAT) begin
			dec.special  = 1'b1;
			dec.spec_val = raw[31:0];
		end else if (fmt == vctf_pkg::FMT_DOUBLE) begin
			dec.sign = raw[63];
			dec.wpre = {1'b1, raw[51:0], 11'd0};
			if (de == 11'h7ff) begin
				dec.special  = 1'b1;
				dec.spec_val = (raw[51:0] == 52'd0) ? ({raw[63], 31'd0} | vctf_pkg::F32_INF)
					: ({raw[63], 31'd0} | vctf_pkg::F32_QNAN | {9'd0, raw[51:29]});
			end else if (de == 11'd0) begin
				dec.special  = 1'b1;
				dec.spec_val = {raw[63], 31'd0};
			end else if (de > 11'd1150) begin
				dec.special  = 1'b1;
				dec.spec_val = {raw[63], 31'd0} | vctf_pkg::F32_INF;
			end else if (de >= 11'd897) begin
				dec.eadj = 8'(de - 11'd897);
			end else if (dsh > 11'd25) begin
				dec.special  = 1'b1;
				dec.spec_val = {raw[63], 31'd0};
			end else begin
				dec.rsh = dsh[4:0];
			end
		end else begin
			dec.special = 1'b1;
		end
	end

endmodule

// ===== rtl/vertex_component_to_float.sv =====
// ----------------------------------------------------------------------------
// vertex_component_to_float
// Converts one raw vertex attribute component to IEEE single precision.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  in       sink       in_valid / in_stall    raw_component[63:0]
//  out      source     out_valid / out_stall  float_bits[31:0]
//  cfg      sink       cfg_we                 cfg_index[3:0], cfg_wdata[3:0]
//
//  One request per cycle unless out_stall holds the pipe; stages decode, align shift, round.
//  Stages advance independently, so bubbles are squeezed out under stall.
//  Reset clears stage valids and loads format float, normalise off.
module vertex_component_to_float (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] raw_component,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] float_bits,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_index,
	input  logic [3:0]  cfg_wdata
);

	logic [3:0]      fmt_q;
	logic            norm_q;
	vctf_pkg::dec_t  dec;
	vctf_pkg::dec_t  d_s1;
	logic            v_s1, v_s2, v_s3;
	logic            en1, en2, en3;
	logic [63:0]     wsh;
	logic [63:0]     lostmask;
	logic [24:0]     w_s2;
	logic            st_s2, sign_s2, spec_s2;
	logic [31:0]     sval_s2;
	logic [7:0]      eadj_s2;
	logic            up;
	logic [30:0]     body;
	logic [31:0]     res_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q  <= vctf_pkg::FMT_FLOAT;
			norm_q <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == vctf_pkg::REG_FORMAT) fmt_q <= cfg_wdata;
			else if (cfg_index == vctf_pkg::REG_NORM) norm_q <= cfg_wdata[0];
		end
	end

	assign en3      = !v_s3 || !out_stall;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_stall = !en1;

	vctf_decode u_dec (
		.fmt  (fmt_q),
		.norm (norm_q),
		.raw  (raw_component),
		.dec  (dec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid) d_s1 <= dec;
	end

	assign wsh      = (d_s1.wpre << d_s1.lsh) >> d_s1.rsh;
	assign lostmask = (64'd1 << d_s1.rsh) - 64'd1;

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			w_s2    <= wsh[63:39];
			st_s2   <= (|wsh[38:0]) || (|(d_s1.wpre & lostmask)) || d_s1.force_st;
			sign_s2 <= d_s1.sign;
			spec_s2 <= d_s1.special;
			sval_s2 <= d_s1.spec_val;
			eadj_s2 <= d_s1.eadj;
		end
	end

	assign up   = w_s2[0] && (st_s2 || w_s2[1]);
	assign body = {eadj_s2, 23'd0} + {7'd0, w_s2[24:1]} + {30'd0, up};

	always_ff @(posedge clk) begin
		if (en3 && v_s2) res_s3 <= spec_s2 ? sval_s2 : {sign_s2, body};
	end

	assign out_valid  = v_s3;
	assign float_bits = res_s3;

endmodule

// ===== rtl/vctf_checker.sv =====
// ----------------------------------------------------------------------------
// vctf_checker
// Port-level checks on the converter, bound to the top level.
// ----------------------------------------------------------------------------
module vctf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] float_bits
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(float_bits))
		else $error("stalled result changed");

	a_no_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) ##1 !out_stall ##1 !out_stall |=> out_valid)
		else $error("request did not reach output");

endmodule

bind vertex_component_to_float vctf_checker u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.float_bits (float_bits)
);

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: vertex component to float converter testbench
// A short table of directed requests, with known results, is followed by
// random phases that change the format and normalisation between bursts.
// Each random request is predicted with round-to-nearest-even integer
// arithmetic; all results are checked in order against the output channel,
// under varying sender idling, receiver stalls and one long receiver hold.
// ----------------------------------------------------------------------------
module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [3:0] FMT_UNKNOWN = 4'd8;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int PHASES = 28;
	localparam int PHASE_ITEMS = 50;

	typedef struct {
		logic [3:0]  fmt;
		logic        norm;
		logic [63:0] raw;
		logic [31:0] want;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [63:0] raw_component;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] float_bits;
	logic        cfg_we;
	logic [3:0]  cfg_index;
	logic [3:0]  cfg_wdata;

	logic [3:0]  fmt_mirror;
	logic        norm_mirror;
	logic [31:0] pending_floats[$];
	dir_row_t    dir_rows[$];
	logic        in_took;
	logic        dir_has;
	logic [31:0] dir_want;
	int          errors = 0;
	int          quiet_cycles = 0;
	int          send_idle_pct;
	int          stall_pct;
	bit          hold_go;
	bit          hold_seen = 1'b0;
	int          hold_cnt = 0;

	vertex_component_to_float uut (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// round-to-nearest-even right shift
	function automatic logic [63:0] rne_shift(input logic [63:0] x, input int sh);
		logic [63:0] q, r, half;
		q = x >> sh;
		r = x & ((64'd1 << sh) - 64'd1);
		half = 64'd1 << (sh - 1);
		if (r > half || (r == half && q[0]))
			q++;
		return q;
	endfunction

	function automatic logic [31:0] int_to_f32(input logic neg, input logic [32:0] mag);
		int p;
		logic [63:0] m;
		if (mag == 0)
			return 32'd0;
		p = 0;
		for (int i = 0; i < 33; i++)
			if (mag[i]) p = i;
		if (p <= 23)
			m = 64'(mag) << (23 - p);
		else
			m = rne_shift(64'(mag), p - 23);
		return {neg, 31'd0} + (32'(p + 126) << 23) + 32'(m);
	endfunction

	// n / d rounded to single precision; n below 2^16
	function automatic logic [31:0] quot_f32(input logic neg, input logic [31:0] n,
		input logic [31:0] d);
		int s;
		logic [63:0] q, r, num;
		logic [31:0] res;
		if (n == 0)
			return 32'd0;
		s = 0;
		num = 64'(n);
		q = num / d;
		while (q < 64'h80_0000) begin
			s++;
			num = 64'(n) << s;
			q = num / d;
		end
		r = num % d;
		if (2 * r > d || (2 * r == 64'(d) && q[0]))
			q++;
		res = (32'(23 - s + 126) << 23) + 32'(q);
		if (neg && res > vctf_pkg::F32_ONE)
			return {1'b1, vctf_pkg::F32_ONE[30:0]};
		return {neg, res[30:0]};
	endfunction

	function automatic logic [31:0] double_to_f32(input logic [63:0] b);
		logic [31:0] sgn;
		logic [10:0] e;
		logic [51:0] m;
		logic [63:0] sig;
		int ex;
		sgn = {b[63], 31'd0};
		e = b[62:52];
		m = b[51:0];
		if (e == 11'h7ff) begin
			if (m == 0)
				return sgn | vctf_pkg::F32_INF;
			return sgn | vctf_pkg::F32_QNAN | 32'(m >> 29);
		end
		if (e == 0)
			return sgn;
		ex = int'(e) - 1023;
		sig = {12'd1, m};
		if (ex > 127)
			return sgn | vctf_pkg::F32_INF;
		if (ex >= -126)
			return sgn + (32'(ex + 126) << 23) + 32'(rne_shift(sig, 29));
		if (-ex - 97 > 54)
			return sgn;
		return sgn | 32'(rne_shift(sig, -ex - 97));
	endfunction

	function automatic logic [31:0] convert_component(input logic [3:0] fmt, input logic norm,
		input logic [63:0] raw);
		case (fmt)
			vctf_pkg::FMT_S8: begin
				if (norm)
					return quot_f32(raw[7], raw[7] ? 32'(-$signed(raw[7:0])) : 32'(raw[7:0]),
						32'd127);
				return int_to_f32(raw[7], raw[7] ? 33'(-$signed(raw[7:0])) : 33'(raw[7:0]));
			end
			vctf_pkg::FMT_U8:
				return norm ? quot_f32(1'b0, 32'(raw[7:0]), 32'd255)
					: int_to_f32(1'b0, 33'(raw[7:0]));
			vctf_pkg::FMT_S16: begin
				if (norm)
					return quot_f32(raw[15], raw[15] ? 32'(-$signed(raw[15:0]))
						: 32'(raw[15:0]), 32'd32767);
				return int_to_f32(raw[15], raw[15] ? 33'(-$signed(raw[15:0]))
					: 33'(raw[15:0]));
			end
			vctf_pkg::FMT_U16:
				return norm ? quot_f32(1'b0, 32'(raw[15:0]), 32'd65535)
					: int_to_f32(1'b0, 33'(raw[15:0]));
			vctf_pkg::FMT_S32:
				return int_to_f32(raw[31], raw[31] ? 33'(-$signed(raw[31:0]))
					: 33'(raw[31:0]));
			vctf_pkg::FMT_U32:
				return int_to_f32(1'b0, 33'(raw[31:0]));
			vctf_pkg::FMT_FLOAT:
				return raw[31:0];
			vctf_pkg::FMT_DOUBLE:
				return double_to_f32(raw);
			default:
				return 32'd0;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_mirror = vctf_pkg::FMT_FLOAT;
			norm_mirror = 1'b0;
			in_took <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == vctf_pkg::REG_FORMAT)
					fmt_mirror = cfg_wdata;
				else if (cfg_index == vctf_pkg::REG_NORM)
					norm_mirror = cfg_wdata[0];
			end
			in_took <= in_valid && !in_stall;
			if (in_valid && !in_stall)
				pending_floats = {pending_floats, (dir_has ? dir_want
					: convert_component(fmt_mirror, norm_mirror, raw_component))};
			if (out_valid && !out_stall) begin
				if (pending_floats.size() == 0) begin
					$display("%0t: unexpected result %h", $time, float_bits);
					errors++;
				end else begin
					if (float_bits !== pending_floats[0]) begin
						$display("%0t: float_bits expected %h actual %h", $time,
							pending_floats[0], float_bits);
						errors++;
					end
					void'(pending_floats.pop_front());
				end
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_go != hold_seen) begin
			hold_seen = hold_go;
			hold_cnt = 300;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			out_stall <= 1'b1;
		end else
			out_stall <= ($urandom_range(99) < stall_pct);
	end

	task automatic send(input logic [63:0] r, input logic has, input logic [31:0] w);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		raw_component <= r;
		dir_has <= has;
		dir_want <= w;
		do @(negedge clk); while (!in_took);
	endtask

	task automatic cfg_write(input logic [3:0] idx, input logic [3:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (pending_floats.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_mode(input int mode);
		send_idle_pct = (mode == 1) ? 46 : (mode == 3) ? 31 : 0;
		stall_pct = (mode == 2) ? 46 : (mode == 3) ? 31 : 0;
	endtask

	task automatic add_row(input logic [3:0] f, input logic n, input logic [63:0] r,
		input logic [31:0] w);
		dir_row_t row;
		row.fmt = f;
		row.norm = n;
		row.raw = r;
		row.want = w;
		dir_rows = {dir_rows, row};
	endtask

	function automatic logic [63:0] random_raw(input logic [3:0] fmt);
		logic [63:0] r;
		r = {$urandom, $urandom};
		if (fmt == vctf_pkg::FMT_DOUBLE) begin
			case ($urandom_range(3))
				1: r[62:52] = 11'($urandom_range(1023 + 129, 1023 - 160));
				2: begin
					r[62:52] = $urandom_range(1) ? 11'h7ff : 11'h000;
					if ($urandom_range(1)) r[51:0] = 52'd0;
				end
				3: begin
					r[62:52] = 11'($urandom_range(1023 + 128, 1023 - 155));
					r[28:0] = $urandom_range(1) ? 29'h1000_0000 : 29'h0fff_ffff;
				end
				default: ;
			endcase
		end
		return r;
	endfunction

	initial begin
		logic [3:0] fmt;
		logic norm;
		arst_n = 1'b0;
		in_valid = 1'b0;
		raw_component = 64'd0;
		cfg_we = 1'b0;
		cfg_index = vctf_pkg::REG_FORMAT;
		cfg_wdata = 4'd0;
		dir_has = 1'b0;
		dir_want = 32'd0;
		hold_go = 1'b0;
		set_mode(0);

		add_row(vctf_pkg::FMT_FLOAT, 1'b0, 64'h1234_5678_3f80_0000, 32'h3f80_0000);
		add_row(vctf_pkg::FMT_FLOAT, 1'b0, 64'hffff_ffff_7fa0_0001, 32'h7fa0_0001);
		add_row(vctf_pkg::FMT_S8, 1'b0, 64'h80, 32'hc300_0000);
		add_row(vctf_pkg::FMT_S8, 1'b0, 64'h7f, 32'h42fe_0000);
		add_row(vctf_pkg::FMT_S8, 1'b1, 64'h80, 32'hbf80_0000);
		add_row(vctf_pkg::FMT_S8, 1'b1, 64'h81, 32'hbf80_0000);
		add_row(vctf_pkg::FMT_S8, 1'b1, 64'h7f, 32'h3f80_0000);
		add_row(vctf_pkg::FMT_S8, 1'b1, 64'hffff_ff00, 32'h0000_0000);
		add_row(vctf_pkg::FMT_U8, 1'b1, 64'hff, 32'h3f80_0000);
		add_row(vctf_pkg::FMT_U8, 1'b0, 64'hff, 32'h437f_0000);
		add_row(vctf_pkg::FMT_S16, 1'b1, 64'h8000, 32'hbf80_0000);
		add_row(vctf_pkg::FMT_S16, 1'b1, 64'h7fff, 32'h3f80_0000);
		add_row(vctf_pkg::FMT_S16, 1'b0, 64'h8000, 32'hc700_0000);
		add_row(vctf_pkg::FMT_U16, 1'b1, 64'hffff, 32'h3f80_0000);
		add_row(vctf_pkg::FMT_U16, 1'b0, 64'hffff, 32'h477f_ff00);
		add_row(vctf_pkg::FMT_S32, 1'b0, 64'h8000_0000, 32'hcf00_0000);
		add_row(vctf_pkg::FMT_S32, 1'b1, 64'h7fff_ffff, 32'h4f00_0000);
		add_row(vctf_pkg::FMT_U32, 1'b1, 64'hffff_ffff, 32'h4f80_0000);
		add_row(vctf_pkg::FMT_DOUBLE, 1'b0, 64'h3ff0_0000_0000_0000, 32'h3f80_0000);
		add_row(vctf_pkg::FMT_DOUBLE, 1'b0, 64'hfff0_0000_0000_0000, 32'hff80_0000);
		add_row(vctf_pkg::FMT_DOUBLE, 1'b0, 64'h7ff8_0000_0000_0001, 32'h7fc0_0000);
		add_row(vctf_pkg::FMT_DOUBLE, 1'b0, 64'h47ef_ffff_ffff_ffff, 32'h7f80_0000);
		add_row(vctf_pkg::FMT_DOUBLE, 1'b0, 64'h8000_0000_0000_0001, 32'h8000_0000);
		add_row(vctf_pkg::FMT_DOUBLE, 1'b0, 64'h36a0_0000_0000_0000, 32'h0000_0001);
		add_row(FMT_UNKNOWN, 1'b1, 64'hffff_ffff_ffff_ffff, 32'h0000_0000);
		add_row(4'hf, 1'b0, 64'h3ff0_0000_0000_0000, 32'h0000_0000);

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].fmt != fmt_mirror || dir_rows[i].norm != norm_mirror) begin
				drain();
				cfg_write(vctf_pkg::REG_FORMAT, dir_rows[i].fmt);
				cfg_write(vctf_pkg::REG_NORM, {3'($urandom), dir_rows[i].norm});
			end
			set_mode(i % 4);
			send(dir_rows[i].raw, 1'b1, dir_rows[i].want);
		end

		for (int p = 0; p < PHASES; p++) begin
			drain();
			fmt = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 8))
				: 4'($urandom_range(7));
			norm = 1'($urandom_range(1));
			cfg_write(4'($urandom_range(15, 2)), 4'($urandom));
			cfg_write(vctf_pkg::REG_FORMAT, fmt);
			cfg_write(vctf_pkg::REG_NORM, {3'($urandom), norm});
			set_mode(p % 4);
			if (p == 5)
				hold_go = ~hold_go;
			for (int k = 0; k < PHASE_ITEMS; k++)
				send(random_raw(fmt), 1'b0, 32'd0);
		end

		in_valid <= 1'b0;
		while (pending_floats.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== vertex_component_to_float.f =====
rtl/vctf_pkg.sv
rtl/vctf_decode.sv
rtl/vertex_component_to_float.sv
rtl/vctf_checker.sv
bench/tb_top.sv
